// File: hw/rtl/hbf_pkg.sv
// Shared types, constants and helper functions of the harmonic bond force pipeline.
// Used by every other file of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hbf_pkg;

  // Coordinate bits taken from each position field, sign-extended from the top one.
  localparam int CoordWidth = 32;

  // APB register map.
  localparam int AddrWidth = 5;
  localparam int DataWidth = 32;

  // Square root: one result bit per bit pair of the 66-bit radicand.
  localparam int SqrtPairs    = 33;
  localparam int SqrtPerStage = 3;
  localparam int SqrtStages   = SqrtPairs / SqrtPerStage;
  localparam int RadWidth     = 2 * SqrtPairs;
  localparam int RootWidth    = SqrtPairs;
  localparam int SqrtRemWidth = RootWidth + 3;

  // Force division: 32 quotient bits with an overflow flag.
  localparam int DrWidth       = RootWidth + 1;
  localparam int DivBits       = 32;
  localparam int DivPerStage   = 2;
  localparam int DivStages     = DivBits / DivPerStage;
  localparam int DivLatency    = DivStages + 1;
  localparam int DivisorWidth  = RootWidth + 16;
  localparam int DividendWidth = 64 + DrWidth;
  localparam int DivRemWidth   = DivisorWidth + DivBits;

  // Register stages from the input register to the final force stage.
  localparam int NumStages = 4 + SqrtStages + 3 + DivLatency + 1;

  typedef enum logic [2:0] {
    RegSpringK   = 3'd0,
    RegBoxX      = 3'd1,
    RegBoxY      = 3'd2,
    RegBoxZ      = 3'd3,
    RegWrapMask  = 3'd4,
    RegEnergyEn  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] spring_k;
    logic [30:0] box_x;
    logic [30:0] box_y;
    logic [30:0] box_z;
    logic [2:0]  wrap_mask;
    logic        energy_en;
  } cfg_t;

  typedef struct packed {
    logic [SqrtRemWidth-1:0] rem;
    logic [RootWidth-1:0]    root;
  } sqrt_acc_t;

  typedef struct packed {
    logic [DivRemWidth-1:0] rem;
    logic [DivBits-1:0]     quo;
    logic                   ovf;
  } div_acc_t;

  // One restoring square-root step on the next bit pair of the radicand.
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [SqrtRemWidth-1:0] rem_sh;
    logic [SqrtRemWidth-1:0] trial;
    sqrt_acc_t res;
    rem_sh = {acc.rem[SqrtRemWidth-3:0], pair};
    trial  = SqrtRemWidth'({acc.root, 2'b01});
    if (rem_sh >= trial) begin
      res.rem  = rem_sh - trial;
      res.root = {acc.root[RootWidth-2:0], 1'b1};
    end else begin
      res.rem  = rem_sh;
      res.root = {acc.root[RootWidth-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hbf_cfg.sv
// APB register file holding the spring constant, box widths, wrap mask and energy enable.
// Depends on hbf_pkg for the register indices and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module hbf_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hbf_pkg::AddrWidth-1:0] paddr,
  input  wire logic [hbf_pkg::DataWidth-1:0] pwdata,
  output logic      [hbf_pkg::DataWidth-1:0] prdata,
  output logic                               pready,
  output hbf_pkg::cfg_t                      cfg_o
);

  hbf_pkg::cfg_t    cfg_q;
  hbf_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = hbf_pkg::reg_idx_e'(paddr[hbf_pkg::AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        hbf_pkg::RegSpringK:  cfg_q.spring_k  <= pwdata;
        hbf_pkg::RegBoxX:     cfg_q.box_x     <= pwdata[30:0];
        hbf_pkg::RegBoxY:     cfg_q.box_y     <= pwdata[30:0];
        hbf_pkg::RegBoxZ:     cfg_q.box_z     <= pwdata[30:0];
        hbf_pkg::RegWrapMask: cfg_q.wrap_mask <= pwdata[2:0];
        hbf_pkg::RegEnergyEn: cfg_q.energy_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hbf_pkg::RegSpringK:  prdata = cfg_q.spring_k;
      hbf_pkg::RegBoxX:     prdata = {1'b0, cfg_q.box_x};
      hbf_pkg::RegBoxY:     prdata = {1'b0, cfg_q.box_y};
      hbf_pkg::RegBoxZ:     prdata = {1'b0, cfg_q.box_z};
      hbf_pkg::RegWrapMask: prdata = {29'd0, cfg_q.wrap_mask};
      hbf_pkg::RegEnergyEn: prdata = {31'd0, cfg_q.energy_en};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/hbf_sqrt.sv
// Pipelined restoring integer square root of the 66-bit squared distance.
// Depends on hbf_pkg for the widths, the stage split and the step function.
`timescale 1ns / 1ps
`default_nettype none

module hbf_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [hbf_pkg::RadWidth-1:0]  rad_i,
  output logic      [hbf_pkg::RootWidth-1:0] root_o
);

  hbf_pkg::sqrt_acc_t             acc_q  [hbf_pkg::SqrtStages];
  hbf_pkg::sqrt_acc_t             acc_d  [hbf_pkg::SqrtStages];
  hbf_pkg::sqrt_acc_t             acc_in [hbf_pkg::SqrtStages];
  logic [hbf_pkg::RadWidth-1:0]   rad_q  [hbf_pkg::SqrtStages-1];
  logic [hbf_pkg::RadWidth-1:0]   rad_in [hbf_pkg::SqrtStages];

  always_comb begin
    acc_in[0] = '0;
    rad_in[0] = rad_i;
    for (int s = 1; s < hbf_pkg::SqrtStages; s++) begin
      acc_in[s] = acc_q[s-1];
      rad_in[s] = rad_q[s-1];
    end
  end

  // Each stage retires three bit pairs, most significant first.
  always_comb begin
    hbf_pkg::sqrt_acc_t acc;
    int p;
    for (int s = 0; s < hbf_pkg::SqrtStages; s++) begin
      acc = acc_in[s];
      for (int j = 0; j < hbf_pkg::SqrtPerStage; j++) begin
        p   = hbf_pkg::SqrtPairs - 1 - (s * hbf_pkg::SqrtPerStage + j);
        acc = hbf_pkg::sqrt_step(acc, rad_in[s][2*p +: 2]);
      end
      acc_d[s] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < hbf_pkg::SqrtStages; s++) begin
        acc_q[s] <= acc_d[s];
      end
      for (int s = 0; s < hbf_pkg::SqrtStages - 1; s++) begin
        rad_q[s] <= rad_in[s];
      end
    end
  end

  assign root_o = acc_q[hbf_pkg::SqrtStages-1].root;

endmodule

`default_nettype wire

// File: hw/rtl/hbf_div.sv
// Pipelined restoring divider giving a 32-bit quotient and an overflow flag.
// Depends on hbf_pkg for the operand widths and the stage split.
`timescale 1ns / 1ps
`default_nettype none

module hbf_div (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [hbf_pkg::DividendWidth-1:0] p_i,
  input  wire logic [hbf_pkg::DivisorWidth-1:0]  d_i,
  output logic      [hbf_pkg::DivBits-1:0]       q_o,
  output logic                                   ovf_o
);

  hbf_pkg::div_acc_t                 acc_q [hbf_pkg::DivLatency];
  hbf_pkg::div_acc_t                 acc_d [hbf_pkg::DivLatency];
  logic [hbf_pkg::DivisorWidth-1:0]  dvs_q [hbf_pkg::DivStages];

  // The first stage flags a quotient of 2^32 or more; the remainder then fits 81 bits.
  // Each later stage retires two quotient bits, most significant first.
  always_comb begin
    hbf_pkg::div_acc_t acc;
    logic [hbf_pkg::DivRemWidth-1:0] t;
    int i;
    acc_d[0].ovf = p_i >= (hbf_pkg::DividendWidth'(d_i) << hbf_pkg::DivBits);
    acc_d[0].rem = p_i[hbf_pkg::DivRemWidth-1:0];
    acc_d[0].quo = '0;
    for (int k = 0; k < hbf_pkg::DivStages; k++) begin
      acc = acc_q[k];
      for (int j = 0; j < hbf_pkg::DivPerStage; j++) begin
        i = hbf_pkg::DivBits - 1 - (k * hbf_pkg::DivPerStage + j);
        t = hbf_pkg::DivRemWidth'(dvs_q[k]) << i;
        if (acc.rem >= t) begin
          acc.rem    = acc.rem - t;
          acc.quo[i] = 1'b1;
        end
      end
      acc_d[k+1] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < hbf_pkg::DivLatency; k++) begin
        acc_q[k] <= acc_d[k];
      end
      dvs_q[0] <= d_i;
      for (int k = 1; k < hbf_pkg::DivStages; k++) begin
        dvs_q[k] <= dvs_q[k-1];
      end
    end
  end

  assign q_o   = acc_q[hbf_pkg::DivLatency-1].quo;
  assign ovf_o = acc_q[hbf_pkg::DivLatency-1].ovf;

endmodule

`default_nettype wire

// File: hw/rtl/harmonic_bond_force_3d.sv
// Top level of the harmonic bond force block: handshakes, displacement, products, output.
// Depends on hbf_pkg, hbf_cfg, hbf_sqrt and hbf_div.
`timescale 1ns / 1ps
`default_nettype none

// Harmonic bond force in three dimensions. Each input beat is one bond; each bond gives
// exactly one output beat carrying the force vector k*(r-r0)*d/r (the caller subtracts it
// from the first particle and adds it to the second), the energy 0.5*k*(r-r0)^2 when the
// energy enable register is set, and the skipped and zero-distance flags. The block takes
// one bond per clock cycle while the skid stage is empty; bonds pass through the 11-stage
// square-root pipeline and the 17-stage divider pipeline that form the distance and the
// force quotient. An output register with a skid stage behind it keeps the input open
// while one finished result waits. Reset clears the configuration registers and the valid
// flags of the stages, the output register and the skid stage; the data registers are not
// reset. Configuration is written over the APB port at byte address 4*index and should
// only be changed while no bond is in flight.

module harmonic_bond_force_3d (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic        [hbf_pkg::AddrWidth-1:0] paddr,
  input  wire logic        [hbf_pkg::DataWidth-1:0] pwdata,
  output logic             [hbf_pkg::DataWidth-1:0] prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [31:0]                 first_x_i,
  input  wire logic signed [31:0]                 first_y_i,
  input  wire logic signed [31:0]                 first_z_i,
  input  wire logic signed [31:0]                 second_x_i,
  input  wire logic signed [31:0]                 second_y_i,
  input  wire logic signed [31:0]                 second_z_i,
  input  wire logic        [30:0]                 rest_length_i,
  input  wire logic                               skip_bond_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed      [31:0]                 force_x_o,
  output logic signed      [31:0]                 force_y_o,
  output logic signed      [31:0]                 force_z_o,
  output logic             [47:0]                 energy_term_o,
  output logic                                    bond_skipped_o,
  output logic                                    zero_distance_o
);

  localparam int RootW = hbf_pkg::RootWidth;
  localparam int DrW   = hbf_pkg::DrWidth;

  // Sideband that rides alongside the square root.
  typedef struct packed {
    logic [2:0][63:0] km;
    logic [2:0]       dneg;
    logic [30:0]      r0;
    logic             skip;
  } sqrt_side_t;

  // Sideband that rides alongside the divider.
  typedef struct packed {
    logic [2:0]  fneg;
    logic        zero;
    logic        skip;
    logic [47:0] energy;
  } div_side_t;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic [47:0] energy;
    logic        skipped;
    logic        zero;
  } res_t;

  hbf_pkg::cfg_t cfg;

  // Pipeline control: every stage moves together while the skid stage is empty.
  logic                      en;
  logic [hbf_pkg::NumStages-1:0] v_q;
  logic                      push;
  logic                      out_v_q, skid_v_q;
  res_t                      out_q, skid_q, res_d;
  res_t                      res_q;

  // Stage 1: input register.
  logic [31:0] pos1_q [3];
  logic [31:0] pos2_q [3];
  logic [30:0] r0_q1;
  logic        skip_q1;

  // Stage 2: wrapped displacement.
  logic [31:0] dm_d [3];
  logic [2:0]  dneg_d;
  logic [31:0] dm_q2 [3];
  logic [2:0]  dneg_q2;
  logic [30:0] r0_q2;
  logic        skip_q2;

  // Stage 3: squares and k*|d|.
  logic [63:0] sq_q3 [3];
  logic [63:0] km_q3 [3];
  logic [2:0]  dneg_q3;
  logic [30:0] r0_q3;
  logic        skip_q3;

  // Stage 4 and the square root.
  logic [hbf_pkg::RadWidth-1:0] sum_q4;
  sqrt_side_t                   sb1_q [hbf_pkg::SqrtStages+1];
  sqrt_side_t                   sb1_in;
  logic [RootW-1:0]             root;

  // Stage A: length error.
  logic signed [DrW-1:0] dr;
  logic [DrW-1:0]        drm_d;
  logic [63:0]           km_qa [3];
  logic [DrW-1:0]        drm_qa;
  logic [2:0]            fneg_qa;
  logic [RootW-1:0]      r_qa;
  logic                  zero_qa;
  logic                  skip_qa;

  // Stage B: partial products.
  logic [65:0]      pplo_qb [3];
  logic [65:0]      pphi_qb [3];
  logic [67:0]      esq_qb;
  logic [2:0]       fneg_qb;
  logic [RootW-1:0] r_qb;
  logic             zero_qb;
  logic             skip_qb;

  // Stage C: dividends and energy partials.
  logic [hbf_pkg::DividendWidth-1:0] p_qc [3];
  logic [65:0]      elo_qc;
  logic [65:0]      ehi_qc;
  logic [2:0]       fneg_qc;
  logic [RootW-1:0] r_qc;
  logic             zero_qc;
  logic             skip_qc;

  logic [99:0]  esum;
  div_side_t    sb2_in;
  div_side_t    sb2_q [hbf_pkg::DivLatency];

  logic [hbf_pkg::DivBits-1:0] quo [3];
  logic [2:0]                  ovf;
  logic [31:0]                 frc [3];

  hbf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign push       = en && v_q[hbf_pkg::NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[hbf_pkg::NumStages-2:0], in_valid_i};
    end
  end

  // Stage 1.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos1_q[0] <= first_x_i;
      pos1_q[1] <= first_y_i;
      pos1_q[2] <= first_z_i;
      pos2_q[0] <= second_x_i;
      pos2_q[1] <= second_y_i;
      pos2_q[2] <= second_z_i;
      r0_q1     <= rest_length_i;
      skip_q1   <= skip_bond_i;
    end
  end

  // Stage 2: difference, then the minimum image where the axis wraps. When the box is
  // narrower than the gap the alternative goes negative and is still taken.
  always_comb begin
    logic signed [32:0] c1, c2;
    logic signed [33:0] diff, alt, magx, sel;
    logic [32:0]        mag33;
    logic [31:0]        mag;
    logic [30:0]        box;
    logic               dpos;
    for (int a = 0; a < 3; a++) begin
      c1    = 33'($signed(pos1_q[a][hbf_pkg::CoordWidth-1:0]));
      c2    = 33'($signed(pos2_q[a][hbf_pkg::CoordWidth-1:0]));
      diff  = 34'(c1) - 34'(c2);
      mag33 = diff[33] ? 33'(-diff) : 33'(diff);
      mag   = mag33[32] ? 32'hFFFF_FFFF : mag33[31:0];
      box   = (a == 0) ? cfg.box_x : ((a == 1) ? cfg.box_y : cfg.box_z);
      magx  = $signed({2'b00, mag});
      alt   = $signed({3'b000, box}) - magx;
      dpos  = !diff[33] && (mag != 32'd0);
      if (cfg.wrap_mask[a] && (alt < magx)) begin
        sel = dpos ? -alt : alt;
      end else begin
        sel = diff[33] ? -magx : magx;
      end
      dneg_d[a] = sel[33];
      dm_d[a]   = sel[33] ? 32'(-sel) : 32'(sel);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        dm_q2[a] <= dm_d[a];
      end
      dneg_q2 <= dneg_d;
      r0_q2   <= r0_q1;
      skip_q2 <= skip_q1;
    end
  end

  // Stage 3.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sq_q3[a] <= dm_q2[a] * dm_q2[a];
        km_q3[a] <= cfg.spring_k * dm_q2[a];
      end
      dneg_q3 <= dneg_q2;
      r0_q3   <= r0_q2;
      skip_q3 <= skip_q2;
    end
  end

  // Stage 4 and the square-root sideband line.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sb1_in.km[a] = km_q3[a];
    end
    sb1_in.dneg = dneg_q3;
    sb1_in.r0   = r0_q3;
    sb1_in.skip = skip_q3;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q4   <= hbf_pkg::RadWidth'(sq_q3[0]) + hbf_pkg::RadWidth'(sq_q3[1])
                + hbf_pkg::RadWidth'(sq_q3[2]);
      sb1_q[0] <= sb1_in;
      for (int s = 1; s <= hbf_pkg::SqrtStages; s++) begin
        sb1_q[s] <= sb1_q[s-1];
      end
    end
  end

  hbf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q4),
    .root_o (root)
  );

  // Stage A: r - r0 and the sign of each force component. A zero root means the
  // squared distance was zero.
  assign dr    = $signed({1'b0, root}) - $signed({3'b000, sb1_q[hbf_pkg::SqrtStages].r0});
  assign drm_d = dr[DrW-1] ? DrW'(-dr) : DrW'(dr);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        km_qa[a]   <= sb1_q[hbf_pkg::SqrtStages].km[a];
        fneg_qa[a] <= sb1_q[hbf_pkg::SqrtStages].dneg[a] ^ dr[DrW-1];
      end
      drm_qa  <= drm_d;
      r_qa    <= root;
      zero_qa <= (root == '0);
      skip_qa <= sb1_q[hbf_pkg::SqrtStages].skip;
    end
  end

  // Stage B: k*|d| times |r - r0| in two halves, and (r - r0)^2.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        pplo_qb[a] <= km_qa[a][31:0] * drm_qa;
        pphi_qb[a] <= km_qa[a][63:32] * drm_qa;
      end
      esq_qb  <= drm_qa * drm_qa;
      fneg_qb <= fneg_qa;
      r_qb    <= r_qa;
      zero_qb <= zero_qa;
      skip_qb <= skip_qa;
    end
  end

  // Stage C.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        p_qc[a] <= hbf_pkg::DividendWidth'(pplo_qb[a])
                 + (hbf_pkg::DividendWidth'(pphi_qb[a]) << 32);
      end
      elo_qc  <= esq_qb[33:0] * cfg.spring_k;
      ehi_qc  <= esq_qb[67:34] * cfg.spring_k;
      fneg_qc <= fneg_qb;
      r_qc    <= r_qb;
      zero_qc <= zero_qb;
      skip_qc <= skip_qb;
    end
  end

  // Energy is k*dr^2 / 2^33, which saturates once the product reaches 2^81.
  always_comb begin
    esum          = 100'(elo_qc) + (100'(ehi_qc) << 34);
    sb2_in.fneg   = fneg_qc;
    sb2_in.zero   = zero_qc;
    sb2_in.skip   = skip_qc;
    sb2_in.energy = (esum[99:81] != '0) ? 48'hFFFF_FFFF_FFFF : esum[80:33];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb2_q[0] <= sb2_in;
      for (int k = 1; k < hbf_pkg::DivLatency; k++) begin
        sb2_q[k] <= sb2_q[k-1];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    hbf_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .p_i   (p_qc[a]),
      .d_i   ({r_qc, 16'd0}),
      .q_o   (quo[a]),
      .ovf_o (ovf[a])
    );
  end

  // Final stage: saturate each component to the signed 32-bit range, or zero it for a skipped bond or zero distance.
  always_comb begin
    div_side_t sb;
    sb = sb2_q[hbf_pkg::DivLatency-1];
    for (int a = 0; a < 3; a++) begin
      if (sb.fneg[a]) begin
        frc[a] = (ovf[a] || (quo[a] > 32'h8000_0000)) ? 32'h8000_0000 : 32'(-quo[a]);
      end else begin
        frc[a] = (ovf[a] || quo[a][31]) ? 32'h7FFF_FFFF : quo[a];
      end
      if (sb.skip || sb.zero) begin
        frc[a] = '0;
      end
    end
    res_d.fx      = frc[0];
    res_d.fy      = frc[1];
    res_d.fz      = frc[2];
    res_d.energy  = (sb.skip || !cfg.energy_en) ? 48'd0 : sb.energy;
    res_d.skipped = sb.skip;
    res_d.zero    = sb.zero && !sb.skip;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  // Output register with a skid stage: a beat leaving the pipeline while the output is
  // held parks in the skid stage, which in turn stops the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : res_q;
    end else if (push) begin
      skid_q <= res_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign force_x_o       = $signed(out_q.fx);
  assign force_y_o       = $signed(out_q.fy);
  assign force_z_o       = $signed(out_q.fz);
  assign energy_term_o   = out_q.energy;
  assign bond_skipped_o  = out_q.skipped;
  assign zero_distance_o = out_q.zero;

endmodule

`default_nettype wire
